// ----- rtl/core/gds_pkg.sv -----
package gds_pkg;

    typedef logic [13:0] year_t;
    typedef logic [3:0]  month_t;
    typedef logic [4:0]  day_t;
    typedef logic [22:0] cnt_t;
    typedef logic [8:0]  msd_t;
    typedef logic [21:0] span_t;

    typedef struct packed {
        year_t  first_year;
        month_t first_month;
        day_t   first_day;
        year_t  second_year;
        month_t second_month;
        day_t   second_day;
    } date_in_t;

    typedef struct packed {
        span_t span_days;
        logic  date_invalid;
    } span_out_t;

    typedef struct packed {
        logic adv_a;
        logic adv_b;
    } lane_ctl_t;

    typedef struct packed {
        cnt_t count;
        logic ok;
    } lane_res_t;

    localparam year_t       FIRST_YEAR         = 14'd1970;
    localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
    localparam cnt_t        LEAPS_BEFORE_FIRST = 23'd477;
    localparam logic [11:0] RECIP_25           = 12'd2622;
    localparam int          RECIP_SHIFT        = 16;
    localparam logic [6:0]  CENTURY            = 7'd100;
    localparam logic [6:0]  CENTURY_LAST       = 7'd99;
    localparam month_t      MONTH_JAN          = 4'd1;
    localparam month_t      MONTH_FEB          = 4'd2;
    localparam month_t      MONTH_DEC          = 4'd12;

    function automatic msd_t month_start(input month_t m);
        msd_t r;
        unique case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic day_t month_len(input month_t m);
        day_t r;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/gregorian_day_span_unit.sv -----
// Each word passes the lane input, lane result and merge registers to m_data.
// One word per cycle unless stalled; two parallel date lanes, each with a
// reciprocal multiply stage and a day-count sum stage, then one merge stage.
// Each stage holds under back-pressure and fills any bubble ahead of it.
// Reset: synchronous, active-low aresetn clears all stage valid flags.
module gregorian_day_span_unit #(
    parameter int LAST_YEAR = 9999
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gds_pkg::date_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gds_pkg::span_out_t m_data
);

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic m_valid_reg, m_valid_next;
    logic adv1, adv2, adv3;
    gds_pkg::lane_ctl_t ctl;
    gds_pkg::lane_res_t res_a, res_b;

    assign adv3    = !m_valid_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    assign ctl.adv_a = adv1;
    assign ctl.adv_b = adv2;

    always_comb begin
        v1_next      = adv1 ? s_valid : v1_reg;
        v2_next      = adv2 ? v1_reg : v2_reg;
        m_valid_next = adv3 ? v2_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    gds_lane #(.LAST_YEAR(LAST_YEAR)) u_lane_first (
        .aclk  (aclk),
        .ctl   (ctl),
        .year  (s_data.first_year),
        .month (s_data.first_month),
        .day   (s_data.first_day),
        .res   (res_a)
    );

    gds_lane #(.LAST_YEAR(LAST_YEAR)) u_lane_second (
        .aclk  (aclk),
        .ctl   (ctl),
        .year  (s_data.second_year),
        .month (s_data.second_month),
        .day   (s_data.second_day),
        .res   (res_b)
    );

    gds_merge u_merge (
        .aclk   (aclk),
        .adv    (adv3),
        .res_a  (res_a),
        .res_b  (res_b),
        .result (m_data)
    );

    assign m_valid = m_valid_reg;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.date_invalid |-> m_data.span_days == '0)
        else $error("invalid word carries a nonzero span");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted word lost at first stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && m_valid_reg && !m_ready |=> v2_reg && m_valid_reg)
        else $error("stalled pipeline dropped a word");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !v1_reg && !v2_reg && !m_valid_reg)
        else $error("stage valid set after reset");

endmodule

// ----- rtl/core/gds_lane.sv -----
module gds_lane #(
    parameter int LAST_YEAR = 9999
) (
    input  logic               aclk,
    input  gds_pkg::lane_ctl_t ctl,
    input  gds_pkg::year_t     year,
    input  gds_pkg::month_t    month,
    input  gds_pkg::day_t      day,
    output gds_pkg::lane_res_t res
);

    localparam logic [16:0] LastYear = 17'(LAST_YEAR);

    gds_pkg::cnt_t   yrs_days_reg, yrs_days_next;
    logic [11:0]     q4_reg, q4_next;
    logic [7:0]      q100_reg, q100_next;
    gds_pkg::year_t  ym1_reg, ym1_next;
    gds_pkg::month_t month_reg;
    gds_pkg::day_t   day_reg;
    gds_pkg::msd_t   msd_reg, msd_next;
    logic            range_ok_reg, range_ok_next;
    gds_pkg::lane_res_t res_reg, res_next;

    gds_pkg::year_t  yoff;
    logic [23:0]     prod;
    gds_pkg::year_t  cent_base;
    gds_pkg::year_t  rem;
    logic            div4, cent, lp;
    gds_pkg::day_t   len;
    logic            day_ok;
    gds_pkg::cnt_t   leaps;

    always_comb begin
        ym1_next      = year - 14'd1;
        yoff          = year - gds_pkg::FIRST_YEAR;
        q4_next       = ym1_next[13:2];
        prod          = {12'b0, q4_next} * {12'b0, gds_pkg::RECIP_25};
        q100_next     = prod[gds_pkg::RECIP_SHIFT +: 8];
        yrs_days_next = gds_pkg::cnt_t'(yoff) * gds_pkg::cnt_t'(gds_pkg::DAYS_PER_YEAR);
        msd_next      = gds_pkg::month_start(month) + gds_pkg::msd_t'(day);
        range_ok_next = (year >= gds_pkg::FIRST_YEAR) && ({3'b0, year} <= LastYear)
                        && (month >= gds_pkg::MONTH_JAN) && (month <= gds_pkg::MONTH_DEC);
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv_a) begin
            yrs_days_reg <= yrs_days_next;
            q4_reg       <= q4_next;
            q100_reg     <= q100_next;
            ym1_reg      <= ym1_next;
            month_reg    <= month;
            day_reg      <= day;
            msd_reg      <= msd_next;
            range_ok_reg <= range_ok_next;
        end
    end

    always_comb begin
        cent_base = gds_pkg::year_t'(q100_reg) * gds_pkg::year_t'(gds_pkg::CENTURY);
        rem       = ym1_reg - cent_base;
        div4      = (ym1_reg[1:0] == 2'b11);
        cent      = div4 && (rem == gds_pkg::year_t'(gds_pkg::CENTURY_LAST));
        lp        = div4 && (!cent || (q100_reg[1:0] == 2'b11));
        len       = gds_pkg::month_len(month_reg)
                    + gds_pkg::day_t'((month_reg == gds_pkg::MONTH_FEB) && lp);
        day_ok    = (day_reg != 5'd0) && (day_reg <= len);
        leaps     = gds_pkg::cnt_t'(q4_reg) - gds_pkg::cnt_t'(q100_reg)
                    + gds_pkg::cnt_t'(q100_reg[7:2]) - gds_pkg::LEAPS_BEFORE_FIRST;
        res_next.count = yrs_days_reg + leaps + gds_pkg::cnt_t'(msd_reg)
                         + gds_pkg::cnt_t'((month_reg > gds_pkg::MONTH_FEB) && lp);
        res_next.ok    = range_ok_reg && day_ok;
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv_b) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- rtl/core/gds_merge.sv -----
module gds_merge (
    input  logic               aclk,
    input  logic               adv,
    input  gds_pkg::lane_res_t res_a,
    input  gds_pkg::lane_res_t res_b,
    output gds_pkg::span_out_t result
);

    gds_pkg::span_out_t result_reg, result_next;
    gds_pkg::cnt_t      diff;

    always_comb begin
        diff = (res_a.count >= res_b.count) ? res_a.count - res_b.count
                                            : res_b.count - res_a.count;
        if (res_a.ok && res_b.ok) begin
            result_next.span_days    = diff[21:0];
            result_next.date_invalid = 1'b0;
        end else begin
            result_next.span_days    = '0;
            result_next.date_invalid = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- dv/gregorian_day_span_unit_tb.sv -----
`timescale 1ns / 100ps

module gregorian_day_span_unit_tb;

    localparam int LAST_VALID_YEAR = 9999;
    localparam int EPOCH_YEAR      = 1970;
    localparam int QUIET_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 12;
    localparam int WORDS_PER_PHASE = 232;
    localparam int PHASE_COUNT     = 4;

    class date_span_ledger;
        gds_pkg::span_out_t pending_spans[$];
        int                 mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function bit leap_year(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int days_in_month(int y, int m);
            case (m) inside
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        static function int leaps_through(int y);
            return y / 4 - y / 100 + y / 400;
        endfunction

        static function bit date_valid(int y, int m, int d);
            if (y < EPOCH_YEAR || y > LAST_VALID_YEAR) return 1'b0;
            if (m < 1 || m > 12) return 1'b0;
            return d >= 1 && d <= days_in_month(y, m);
        endfunction

        static function int epoch_day(int y, int m, int d);
            int n;
            n = 365 * (y - EPOCH_YEAR) + leaps_through(y - 1) - leaps_through(EPOCH_YEAR - 1);
            for (int k = 1; k < m; k++) n += days_in_month(y, k);
            return n + d;
        endfunction

        function gds_pkg::span_out_t predict_span(gds_pkg::date_in_t w);
            gds_pkg::span_out_t r;
            int                 a;
            int                 b;
            r = '0;
            if (!date_valid(w.first_year, w.first_month, w.first_day) ||
                !date_valid(w.second_year, w.second_month, w.second_day)) begin
                r.date_invalid = 1'b1;
                return r;
            end
            a = epoch_day(w.first_year, w.first_month, w.first_day);
            b = epoch_day(w.second_year, w.second_month, w.second_day);
            r.span_days = gds_pkg::span_t'((a >= b) ? a - b : b - a);
            return r;
        endfunction

        function void note_word(gds_pkg::date_in_t w);
            pending_spans.push_back(predict_span(w));
        endfunction

        function void check_word(gds_pkg::span_out_t got);
            gds_pkg::span_out_t want;
            if (pending_spans.size() == 0) begin
                $error("unexpected result word: span_days %0d, date_invalid %0d",
                       got.span_days, got.date_invalid);
                mismatches++;
                return;
            end
            want = pending_spans.pop_front();
            if (got.span_days !== want.span_days) begin
                $error("span_days: expected %0d, actual %0d", want.span_days, got.span_days);
                mismatches++;
            end
            if (got.date_invalid !== want.date_invalid) begin
                $error("date_invalid: expected %0d, actual %0d",
                       want.date_invalid, got.date_invalid);
                mismatches++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    gds_pkg::date_in_t  s_data;
    logic               m_valid;
    logic               m_ready;
    gds_pkg::span_out_t m_data;

    date_span_ledger ledger = new();
    int idle_pct;
    int stall_pct;
    int hold_off_left;
    int quiet_cycles;

    gregorian_day_span_unit #(.LAST_YEAR(LAST_VALID_YEAR)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic gds_pkg::date_in_t pair_of(int y1, int m1, int d1,
                                                  int y2, int m2, int d2);
        gds_pkg::date_in_t w;
        w.first_year   = gds_pkg::year_t'(y1);
        w.first_month  = gds_pkg::month_t'(m1);
        w.first_day    = gds_pkg::day_t'(d1);
        w.second_year  = gds_pkg::year_t'(y2);
        w.second_month = gds_pkg::month_t'(m2);
        w.second_day   = gds_pkg::day_t'(d2);
        return w;
    endfunction

    function automatic logic [22:0] random_date();
        int y;
        int m;
        int d;
        int len;
        if ($urandom_range(9) == 0) return 23'($urandom);
        case ($urandom_range(7))
            0:       y = EPOCH_YEAR + $urandom_range(3);
            1:       y = LAST_VALID_YEAR - $urandom_range(3);
            2:       y = 400 * $urandom_range(24, 5);
            3:       y = 100 * $urandom_range(99, 20);
            default: y = $urandom_range(LAST_VALID_YEAR, EPOCH_YEAR);
        endcase
        m   = $urandom_range(12, 1);
        len = date_span_ledger::days_in_month(y, m);
        d   = ($urandom_range(3) == 0) ? len : $urandom_range(len, 1);
        // hit the leap day, valid or not
        if ($urandom_range(7) == 0) begin
            m = int'(gds_pkg::MONTH_FEB);
            d = 28 + $urandom_range(1);
        end
        return {gds_pkg::year_t'(y), gds_pkg::month_t'(m), gds_pkg::day_t'(d)};
    endfunction

    function automatic gds_pkg::date_in_t random_pair();
        gds_pkg::date_in_t w;
        {w.first_year, w.first_month, w.first_day}    = random_date();
        {w.second_year, w.second_month, w.second_day} = random_date();
        return w;
    endfunction

    task automatic offer_word(gds_pkg::date_in_t w);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_left > 0) begin
                m_ready <= 1'b0;
                hold_off_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) ledger.note_word(s_data);
            if (m_valid && m_ready) ledger.check_word(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("gregorian_day_span_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        idle_pct      = 0;
        stall_pct     = 0;
        hold_off_left = 0;
        quiet_cycles  = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer_word(pair_of(1970, 1, 1, 1970, 1, 1));
        offer_word(pair_of(1970, 1, 1, 9999, 12, 31));
        offer_word(pair_of(9999, 12, 31, 1970, 1, 1));
        offer_word(pair_of(2000, 2, 29, 2000, 3, 1));
        offer_word(pair_of(2100, 2, 28, 2100, 3, 1));
        offer_word(pair_of(2100, 2, 29, 2100, 3, 1));
        offer_word(pair_of(2004, 2, 29, 2003, 2, 28));
        offer_word(pair_of(2003, 2, 29, 2003, 3, 1));
        offer_word(pair_of(1969, 12, 31, 1970, 1, 1));
        offer_word(pair_of(1970, 1, 1, 10000, 1, 1));
        offer_word(pair_of(0, 1, 1, 1970, 1, 1));
        offer_word(pair_of(16383, 15, 31, 16383, 15, 31));
        offer_word(pair_of(1999, 0, 10, 1999, 1, 10));
        offer_word(pair_of(1999, 13, 10, 1999, 1, 10));
        offer_word(pair_of(1999, 15, 10, 1999, 1, 10));
        offer_word(pair_of(2023, 5, 0, 2023, 5, 1));
        offer_word(pair_of(2023, 4, 31, 2023, 4, 30));
        offer_word(pair_of(2023, 4, 30, 2023, 6, 30));
        offer_word(pair_of(1980, 7, 4, 2023, 11, 0));
        offer_word(pair_of(2400, 12, 31, 2399, 12, 31));
        offer_word(pair_of(1971, 12, 31, 9998, 1, 1));
        offer_word(pair_of(5000, 8, 31, 5000, 9, 31));

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                    hold_off_left = HOLD_OFF_CYCLES;
                end
                1: begin
                    idle_pct = 86;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 86;
                end
                default: begin
                    idle_pct = 32;
                    stall_pct = 32;
                end
            endcase
            repeat (WORDS_PER_PHASE) offer_word(random_pair());
        end
        s_valid <= 1'b0;

        while (ledger.pending_spans.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.pending_spans.size() == 0) begin
            $display("gregorian_day_span_unit regression: pass");
        end else begin
            $display("gregorian_day_span_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/gds_pkg.sv
rtl/core/gds_lane.sv
rtl/core/gds_merge.sv
rtl/core/gregorian_day_span_unit.sv
dv/gregorian_day_span_unit_tb.sv
